>>> src/alsq_pkg.sv
// shared types, constants and register codes for the automatic light switch qualifier
// no dependencies; imported by every module of the block

package alsq_pkg;

   // field widths
   localparam int LEVEL_W = 8;
   localparam int COUNT_W = 14;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // qualification run lengths and lock hold time, in sample ticks
   localparam logic [COUNT_W-1:0] ON_QUALIFY_SAMPLES = COUNT_W'(200);
   localparam logic [COUNT_W-1:0] OFF_QUALIFY_SAMPLES = COUNT_W'(300);
   localparam logic [COUNT_W-1:0] LOCK_HOLD_TICKS = COUNT_W'(10000);

   // register reset values
   localparam logic [LEVEL_W-1:0] PARK_ON_LEVEL_RST = 8'd180;
   localparam logic [LEVEL_W-1:0] PARK_OFF_LEVEL_RST = 8'd155;
   localparam logic [LEVEL_W-1:0] BEAM_ON_LEVEL_RST = 8'd230;
   localparam logic [LEVEL_W-1:0] BEAM_OFF_LEVEL_RST = 8'd160;
   localparam logic [LEVEL_W-1:0] PARK_ON_ABORT_RST = 8'd170;
   localparam logic [LEVEL_W-1:0] BEAM_ON_ABORT_RST = 8'd220;
   localparam logic [LEVEL_W-1:0] PARK_OFF_ABORT_RST = 8'd145;
   localparam logic [LEVEL_W-1:0] BEAM_OFF_ABORT_RST = 8'd150;

   // register index codes (byte address / 4)
   typedef enum logic [2:0] {
      REG_PARK_ON_LEVEL  = 3'd0,
      REG_PARK_OFF_LEVEL = 3'd1,
      REG_BEAM_ON_LEVEL  = 3'd2,
      REG_BEAM_OFF_LEVEL = 3'd3,
      REG_PARK_ON_ABORT  = 3'd4,
      REG_BEAM_ON_ABORT  = 3'd5,
      REG_PARK_OFF_ABORT = 3'd6,
      REG_BEAM_OFF_ABORT = 3'd7
   } reg_index_type;

   // sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_PARK_ON  = 3'd1,
      PH_BEAM_ON  = 3'd2,
      PH_PARK_OFF = 3'd3,
      PH_BEAM_OFF = 3'd4,
      PH_HOLD     = 3'd5
   } phase_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] park_on_level;
      logic [LEVEL_W-1:0] park_off_level;
      logic [LEVEL_W-1:0] beam_on_level;
      logic [LEVEL_W-1:0] beam_off_level;
      logic [LEVEL_W-1:0] park_on_abort;
      logic [LEVEL_W-1:0] beam_on_abort;
      logic [LEVEL_W-1:0] park_off_abort;
      logic [LEVEL_W-1:0] beam_off_abort;
   } cfg_type;

   typedef struct packed {
      logic                park_button_pressed;
      logic                lock_pressed;
      logic                ignition_on;
      logic [LEVEL_W-1:0]  light_level;
   } sample_type;

   typedef struct packed {
      logic beam_light;
      logic park_light;
   } lights_type;

   typedef struct packed {
      phase_type           phase;
      logic [COUNT_W-1:0]  run_count;
   } status_type;

endpackage

>>> src/alsq_csr.sv
// configuration register bank for the light switch qualifier
// depends on alsq_pkg for the register codes and the config struct

module alsq_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [alsq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [alsq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [alsq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output alsq_pkg::cfg_type                cfg
);
   import alsq_pkg::*;

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   reg_index_type      index;
   logic               wr_en;
   logic [LEVEL_W-1:0] wr_byte;
   logic [LEVEL_W-1:0] rd_byte;

   assign csr_pready = 1'b1;
   assign index = reg_index_type'(csr_paddr[4:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_byte = csr_pwdata[LEVEL_W-1:0];

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_PARK_ON_LEVEL:  cfg_in.park_on_level = wr_byte;
            REG_PARK_OFF_LEVEL: cfg_in.park_off_level = wr_byte;
            REG_BEAM_ON_LEVEL:  cfg_in.beam_on_level = wr_byte;
            REG_BEAM_OFF_LEVEL: cfg_in.beam_off_level = wr_byte;
            REG_PARK_ON_ABORT:  cfg_in.park_on_abort = wr_byte;
            REG_BEAM_ON_ABORT:  cfg_in.beam_on_abort = wr_byte;
            REG_PARK_OFF_ABORT: cfg_in.park_off_abort = wr_byte;
            REG_BEAM_OFF_ABORT: cfg_in.beam_off_abort = wr_byte;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // read decode
   always_comb begin
      unique case (index)
         REG_PARK_ON_LEVEL:  rd_byte = cfg_ff.park_on_level;
         REG_PARK_OFF_LEVEL: rd_byte = cfg_ff.park_off_level;
         REG_BEAM_ON_LEVEL:  rd_byte = cfg_ff.beam_on_level;
         REG_BEAM_OFF_LEVEL: rd_byte = cfg_ff.beam_off_level;
         REG_PARK_ON_ABORT:  rd_byte = cfg_ff.park_on_abort;
         REG_BEAM_ON_ABORT:  rd_byte = cfg_ff.beam_on_abort;
         REG_PARK_OFF_ABORT: rd_byte = cfg_ff.park_off_abort;
         REG_BEAM_OFF_ABORT: rd_byte = cfg_ff.beam_off_abort;
         default:            rd_byte = '0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-LEVEL_W){1'b0}}, rd_byte};
   assign cfg = cfg_ff;

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.park_on_level <= PARK_ON_LEVEL_RST;
         cfg_ff.park_off_level <= PARK_OFF_LEVEL_RST;
         cfg_ff.beam_on_level <= BEAM_ON_LEVEL_RST;
         cfg_ff.beam_off_level <= BEAM_OFF_LEVEL_RST;
         cfg_ff.park_on_abort <= PARK_ON_ABORT_RST;
         cfg_ff.beam_on_abort <= BEAM_ON_ABORT_RST;
         cfg_ff.park_off_abort <= PARK_OFF_ABORT_RST;
         cfg_ff.beam_off_abort <= BEAM_OFF_ABORT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/alsq_core.sv
// qualification sequencer: phase, run counter and light state, one sample per step
// depends on alsq_pkg for the phase enum, structs and run lengths

module alsq_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  alsq_pkg::sample_type  sample,
   input  alsq_pkg::cfg_type     cfg,
   output alsq_pkg::lights_type  lights_next,
   output alsq_pkg::status_type  status
);
   import alsq_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               park_ff, park_in;
   logic               beam_ff, beam_in;
   phase_type          phase_cur;
   logic [COUNT_W-1:0] count_inc;
   logic [LEVEL_W-1:0] s;
   logic               ign;
   logic               btn;

   assign s = sample.light_level;
   assign ign = sample.ignition_on;
   assign btn = sample.park_button_pressed;
   assign count_inc = count_ff + COUNT_W'(1);

   // next phase, counter and lights for one sample
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      park_in = park_ff;
      beam_in = beam_ff;

      // ignition off drops any qualification run
      phase_cur = phase_ff;
      if (!ign && (phase_ff == PH_PARK_ON || phase_ff == PH_BEAM_ON ||
                   phase_ff == PH_PARK_OFF || phase_ff == PH_BEAM_OFF)) begin
         phase_cur = PH_IDLE;
      end

      unique case (phase_cur)
         PH_PARK_ON, PH_BEAM_ON: begin
            if (s < ((phase_cur == PH_PARK_ON) ? cfg.park_on_abort : cfg.beam_on_abort)) begin
               phase_in = PH_IDLE;
               count_in = '0;
            end else if (count_inc >= ON_QUALIFY_SAMPLES) begin
               if (s > cfg.beam_on_level) beam_in = 1'b1;
               if (phase_cur == PH_PARK_ON && s > cfg.park_on_level) park_in = 1'b1;
               phase_in = PH_IDLE;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_PARK_OFF, PH_BEAM_OFF: begin
            if (s > ((phase_cur == PH_PARK_OFF) ? cfg.park_off_abort : cfg.beam_off_abort)) begin
               phase_in = PH_IDLE;
               count_in = '0;
            end else if (count_inc >= OFF_QUALIFY_SAMPLES) begin
               if (phase_cur == PH_PARK_OFF) begin
                  if (s < cfg.park_off_level) park_in = 1'b0;
               end else begin
                  if (s < cfg.beam_off_level) beam_in = 1'b0;
               end
               phase_in = PH_IDLE;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_HOLD: begin
            // hold ends on ignition or timeout, then the button decides
            if (ign || count_inc >= LOCK_HOLD_TICKS) begin
               park_in = btn;
               beam_in = 1'b0;
               phase_in = PH_IDLE;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         default: begin
            // idle, and any unused code
            phase_in = PH_IDLE;
            count_in = '0;
            if (ign) begin
               if (s > cfg.park_on_level && !park_ff) phase_in = PH_PARK_ON;
               else if (s > cfg.beam_on_level && !beam_ff) phase_in = PH_BEAM_ON;
               else if (s < cfg.park_off_level && park_ff) phase_in = PH_PARK_OFF;
               else if (s < cfg.beam_off_level && beam_ff) phase_in = PH_BEAM_OFF;
            end else if (sample.lock_pressed && s > cfg.park_on_level) begin
               park_in = 1'b1;
               beam_in = 1'b1;
               phase_in = PH_HOLD;
            end else if (btn) begin
               park_in = 1'b1;
            end else begin
               park_in = 1'b0;
               beam_in = 1'b0;
            end
         end
      endcase
   end

   assign lights_next.park_light = park_in;
   assign lights_next.beam_light = beam_in;
   assign status.phase = phase_ff;
   assign status.run_count = count_ff;

   // state registers, updated once per stepped sample
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         park_ff <= 1'b0;
         beam_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         park_ff <= park_in;
         beam_ff <= beam_in;
      end
   end

endmodule

>>> src/auto_light_switch_qualifier.sv
// automatic light switch qualifier, top level: input stage, sequencer, result register
// a sample beat is registered in the input stage, then its result beat in the result register
// throughput: one sample beat per cycle while the result channel does not stall
// reset: synchronous, clears the valid flags of both stages, the sequencer (idle, lights off, count zero)
// and loads the register bank with its default levels
// depends on alsq_pkg, alsq_csr and alsq_core

module auto_light_switch_qualifier (
   input  logic                             clock,
   input  logic                             reset,
   // sample channel; tdata: light_level[7:0], ignition_on, lock_pressed,
   // park_button_pressed, zero fill
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [alsq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // result channel; tdata: park_light, beam_light, zero fill
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [alsq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [alsq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [alsq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [alsq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import alsq_pkg::*;

   cfg_type     cfg;
   sample_type  s1_sample_ff, s1_sample_in;
   logic        s1_valid_ff, s1_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   lights_type  rsp_lights_ff, rsp_lights_in;
   lights_type  lights_next;
   status_type  status;
   logic        req_fire;
   logic        step;

   alsq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   alsq_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .sample      (s1_sample_ff),
      .cfg         (cfg),
      .lights_next (lights_next),
      .status      (status)
   );

   // handshake: the sample stage moves on whenever the result register is free or its beat is being taken
   assign step = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || step;
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_sample_in = s1_sample_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_sample_in = sample_type'(req_tdata[10:0]);
      end else if (step) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_lights_in = rsp_lights_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_lights_in = lights_next;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_sample_ff <= s1_sample_in;
      rsp_lights_ff <= rsp_lights_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W-2){1'b0}}, rsp_lights_ff.beam_light,
                       rsp_lights_ff.park_light};

   // the run counter is zero whenever the sequencer rests in idle
   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      status.phase == PH_IDLE |-> status.run_count == '0)
      else $error("run counter nonzero in idle");

   // a switch-on run never holds a count at or past its qualify length
   a_on_run_bound: assert property (@(posedge clock) disable iff (reset)
      (status.phase == PH_PARK_ON || status.phase == PH_BEAM_ON)
      |-> status.run_count < ON_QUALIFY_SAMPLES)
      else $error("switch-on run overran its qualify length");

   // a switch-off run never holds a count at or past its qualify length
   a_off_run_bound: assert property (@(posedge clock) disable iff (reset)
      (status.phase == PH_PARK_OFF || status.phase == PH_BEAM_OFF)
      |-> status.run_count < OFF_QUALIFY_SAMPLES)
      else $error("switch-off run overran its qualify length");

   // the lock hold never outlasts its hold time
   a_hold_bound: assert property (@(posedge clock) disable iff (reset)
      status.phase == PH_HOLD |-> status.run_count < LOCK_HOLD_TICKS)
      else $error("lock hold overran its hold time");

   // a stepped sample always leaves a result beat behind
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("stepped sample produced no result beat");

endmodule
